// File: sv/tcpq_pkg.sv
// Package for the three-class priority queue unit.
// Holds the queue sizing constants, the status codes and the controller state type.
// No dependencies.
package tcpq_pkg;

	localparam int DEPTH = 128;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int NUM_CLASSES = 3;
	localparam int CLS_W = 2;
	localparam int ID_W = 32;
	localparam int OCC_W = 8;
	localparam int RAM_ADDR_W = CLS_W + IDX_W;
	localparam int RAM_DEPTH = NUM_CLASSES << IDX_W;

	localparam logic [CLS_W-1:0] CLASS_LOW = 2'd2;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_SERVED   = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} ctrl_state_t;

	localparam logic MODE_ENQUEUE = 1'b0;
	localparam logic MODE_DEQUEUE = 1'b1;

endpackage

// File: sv/three_class_priority_queue_unit.sv
// Three-class priority queue: one ring per class kept in a shared RAM, capacity shared.
// An enqueue or refused transaction gives its result in the cycle after acceptance; a
// dequeue of a waiting entry gives its result after the RAM's registered read and the S_READ state.
// Sustained rate: one enqueue per cycle while the result is taken; no transaction is taken during S_READ.
// Reset (arst_n, asynchronous) empties the queue; RAM contents need no clearing.
// Depends on tcpq_pkg and tcpq_ram.
module three_class_priority_queue_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [tcpq_pkg::ID_W-1:0]   entry_id,
	input  logic [tcpq_pkg::CLS_W-1:0]  priority_class,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [tcpq_pkg::ID_W-1:0]   served_id,
	output logic [tcpq_pkg::CLS_W-1:0]  served_class,
	output logic [tcpq_pkg::OCC_W-1:0]  occupancy
);
	import tcpq_pkg::*;

	ctrl_state_t            state_q;
	logic [IDX_W-1:0]       head_q [NUM_CLASSES];
	logic [IDX_W-1:0]       tail_q [NUM_CLASSES];
	logic [CNT_W-1:0]       cls_cnt_q [NUM_CLASSES];
	logic [CNT_W-1:0]       total_q;

	logic                   out_valid_q;
	status_t                status_q;
	logic [ID_W-1:0]        served_id_q;
	logic [CLS_W-1:0]       served_class_q;
	logic [OCC_W-1:0]       occupancy_q;
	logic [CLS_W-1:0]       rd_cls_q;

	logic                   accept;
	logic                   is_full;
	logic                   is_empty;
	logic [CLS_W-1:0]       enq_cls;
	logic [CLS_W-1:0]       deq_cls;
	logic                   do_enq;
	logic                   do_deq;
	logic [ID_W-1:0]        rd_data;
	logic [RAM_ADDR_W-1:0]  wr_addr;
	logic [RAM_ADDR_W-1:0]  rd_addr;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p);
		next_idx = (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_full  = (total_q == CNT_W'(DEPTH));
	assign is_empty = (total_q == '0);
	assign enq_cls  = (priority_class > CLASS_LOW) ? CLASS_LOW : priority_class;

	always_comb begin
		if (cls_cnt_q[0] != '0) begin
			deq_cls = 2'd0;
		end else if (cls_cnt_q[1] != '0) begin
			deq_cls = 2'd1;
		end else begin
			deq_cls = 2'd2;
		end
	end

	assign do_enq  = accept && (mode == MODE_ENQUEUE) && !is_full;
	assign do_deq  = accept && (mode == MODE_DEQUEUE) && !is_empty;
	assign wr_addr = {enq_cls, tail_q[enq_cls]};
	assign rd_addr = {deq_cls, head_q[deq_cls]};

	tcpq_ram #(
		.WIDTH(ID_W),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (do_enq),
		.wr_addr (wr_addr),
		.wr_data (entry_id),
		.rd_en   (do_deq),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c]    <= '0;
				tail_q[c]    <= '0;
				cls_cnt_q[c] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (do_enq) begin
						tail_q[enq_cls]    <= next_idx(tail_q[enq_cls]);
						cls_cnt_q[enq_cls] <= cls_cnt_q[enq_cls] + 1'b1;
						total_q            <= total_q + 1'b1;
					end else if (do_deq) begin
						head_q[deq_cls]    <= next_idx(head_q[deq_cls]);
						cls_cnt_q[deq_cls] <= cls_cnt_q[deq_cls] - 1'b1;
						total_q            <= total_q - 1'b1;
						state_q            <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && !do_deq) begin
			out_valid_q <= 1'b1;
		end else if (state_q == S_READ) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			served_id_q    <= '0;
			served_class_q <= '0;
			rd_cls_q       <= deq_cls;
			if (mode == MODE_ENQUEUE) begin
				if (is_full) begin
					status_q    <= ST_FULL;
					occupancy_q <= OCC_W'(total_q);
				end else begin
					status_q    <= ST_ENQUEUED;
					occupancy_q <= OCC_W'(total_q + 1'b1);
				end
			end else begin
				if (is_empty) begin
					status_q    <= ST_EMPTY;
					occupancy_q <= OCC_W'(total_q);
				end else begin
					status_q    <= ST_SERVED;
					occupancy_q <= OCC_W'(total_q - 1'b1);
				end
			end
		end else if (state_q == S_READ) begin
			served_id_q    <= rd_data;
			served_class_q <= rd_cls_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign served_id    = served_id_q;
	assign served_class = served_class_q;
	assign occupancy    = occupancy_q;

endmodule

// File: sv/tcpq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
